// ===== rtl/spbd_pkg.sv =====
// shared types and constants for the steering pwm bridge driver
package spbd_pkg;

	localparam int DUTY_W   = 7;
	localparam int SAMPLE_W = 10;
	localparam int FS_W     = 13;
	localparam int SCALED_W = 23;
	localparam int REMAIN_W = 21;
	localparam int PROD_W   = 28;
	localparam int QUOT_W   = 7;

	// 10 mV and 2000 mV, both scaled by 1023 counts
	localparam logic [SCALED_W-1:0] DEAD_BAND = 23'd10230;
	localparam logic [SCALED_W-1:0] DIFF_DEN  = 23'd2046000;

	// floor(2^41 / 2046000), the estimate is exact or one low
	localparam int          RECIP_W     = 49;
	localparam int          RECIP_SHIFT = 41;
	localparam logic [20:0] RECIP_M     = 21'd1074791;

	localparam logic [1:0] CFG_BASE_SPEED    = 2'd0;
	localparam logic [1:0] CFG_REVERSE       = 2'd1;
	localparam logic [1:0] CFG_FULL_SCALE_MV = 2'd2;

	typedef struct packed {
		logic [DUTY_W-1:0] base_speed;
		logic              reverse;
		logic [FS_W-1:0]   full_scale_mv;
	} cfg_t;

	typedef struct packed {
		logic                is_sample;
		logic                left_high;
		logic [SCALED_W-1:0] scaled;
	} op_t;

	// left_pin_a ends up in the lowest bit
	typedef struct packed {
		logic [DUTY_W-1:0] right_level;
		logic [DUTY_W-1:0] left_level;
		logic              right_pin_b;
		logic              right_pin_a;
		logic              left_pin_b;
		logic              left_pin_a;
	} res_t;

endpackage

// ===== rtl/steering_pwm_bridge_driver_top.sv =====
// top level of the two-wheel steering pwm bridge driver
//
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   tuser req_type, tdata samples
// m_*       out  m_tvalid / m_tready   tdata pins and duty levels
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// a tick, a sample inside the dead band and a sample at full cut go from the queue
// straight to the emit state; any other sample takes one multiply, then a reciprocal
// multiply, a back-multiply and one compare for the divide by 2046000 in the back end
// the front stage and a two-entry queue keep accepting while the back end works
// or the result waits on m_tready, until the queue is full
// reset clears state, duties go to 50, pins to zero; cfg_ready is always high
module steering_pwm_bridge_driver_top #(
	parameter int PWM_PERIOD = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,     // req_type
	input  logic [23:0] s_tdata,     // left_sample, right_sample, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_pin_a, left_pin_b, right_pin_a, right_pin_b, left_level,
	// right_level, zero pad
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	spbd_pkg::cfg_t cfg_q;
	spbd_pkg::op_t  front_op;
	spbd_pkg::op_t  queue_op;
	spbd_pkg::res_t res;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	logic           front_busy;
	logic           back_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_speed    <= 7'd50;
			cfg_q.reverse       <= 1'b0;
			cfg_q.full_scale_mv <= 13'd3300;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spbd_pkg::CFG_BASE_SPEED:    cfg_q.base_speed    <= cfg_data[6:0];
				spbd_pkg::CFG_REVERSE:       cfg_q.reverse       <= cfg_data[0];
				spbd_pkg::CFG_FULL_SCALE_MV: cfg_q.full_scale_mv <= cfg_data;
				default:                     cfg_q               <= cfg_q;
			endcase
		end
	end

	spbd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.req_type     (s_tuser),
		.left_sample  (s_tdata[9:0]),
		.right_sample (s_tdata[19:10]),
		.cfg          (cfg_q),
		.push         (push),
		.op           (front_op),
		.q_full       (q_full),
		.busy         (front_busy)
	);

	spbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (front_op),
		.pop     (pop),
		.pop_op  (queue_op),
		.full    (q_full),
		.empty   (q_empty)
	);

	spbd_back #(
		.PWM_PERIOD (PWM_PERIOD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.op        (queue_op),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.busy      (back_busy)
	);

	assign m_tdata = {6'd0, res};

	// a new result only comes out of a back end that was working on an item
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(back_busy))
		else $error("result raised with back end idle");

	// an accepted transaction is held in the front stage on the next cycle
	a_front_takes_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> front_busy)
		else $error("accepted transaction lost by front stage");

	// the front stage only stalls while the queue is full
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		front_busy && !q_full |=> !$past(s_tready) || front_busy || !q_empty)
		else $error("front stage drained without queue entry");

endmodule

// ===== rtl/spbd_front.sv =====
// front end: takes items, works out the scaled sample difference
module spbd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [9:0]          left_sample,
	input  logic [9:0]          right_sample,
	input  spbd_pkg::cfg_t      cfg,
	output logic                push,
	output spbd_pkg::op_t       op,
	input  logic                q_full,
	output logic                busy
);

	logic                             valid_s1;
	spbd_pkg::op_t                    op_s1;
	logic                             left_high;
	logic [spbd_pkg::SAMPLE_W-1:0]    mag;
	logic [spbd_pkg::SCALED_W-1:0]    scaled;

	always_comb begin
		left_high = (left_sample >= right_sample);
		mag       = left_high ? (left_sample - right_sample) : (right_sample - left_sample);
		scaled    = spbd_pkg::SCALED_W'(mag) * spbd_pkg::SCALED_W'(cfg.full_scale_mv);
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign op       = op_s1;
	assign busy     = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1.is_sample <= req_type;
			op_s1.left_high <= left_high;
			op_s1.scaled    <= scaled;
		end
	end

endmodule

// ===== rtl/spbd_queue.sv =====
// two-entry queue between front end and back end
module spbd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spbd_pkg::op_t push_op,
	input  logic          pop,
	output spbd_pkg::op_t pop_op,
	output logic          full,
	output logic          empty
);

	spbd_pkg::op_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign pop_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== rtl/spbd_back.sv =====
// back end: duty update with reciprocal divide, pwm phase and bridge pins
module spbd_back #(
	parameter int PWM_PERIOD = 100
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  spbd_pkg::op_t  op,
	output logic           pop,
	input  spbd_pkg::cfg_t cfg,
	output logic           out_valid,
	input  logic           out_ready,
	output spbd_pkg::res_t out_res,
	output logic           busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [7:0] PERIOD_CNT = 8'(PWM_PERIOD);

	logic [1:0]                        state_q;
	logic [spbd_pkg::DUTY_W-1:0]       phase_q;
	logic [spbd_pkg::DUTY_W-1:0]       left_duty_q;
	logic [spbd_pkg::DUTY_W-1:0]       right_duty_q;
	logic [3:0]                        pins_q;
	logic                              left_high_q;
	logic [spbd_pkg::REMAIN_W-1:0]     remain_q;
	logic [spbd_pkg::PROD_W-1:0]       rem_q;
	logic [spbd_pkg::QUOT_W-1:0]       quot_q;
	logic [2:0]                        step_q;
	logic                              out_valid_q;
	spbd_pkg::res_t                    out_res_q;

	logic [spbd_pkg::DUTY_W-1:0]       ph_inc;
	logic [spbd_pkg::DUTY_W-1:0]       ph_next;
	logic                              left_on;
	logic                              right_on;
	logic [3:0]                        pins_next;
	logic [spbd_pkg::RECIP_W-1:0]      recip_prod;
	logic [spbd_pkg::QUOT_W-1:0]       quot_fix;

	always_comb begin
		ph_inc  = phase_q + 7'd1;
		ph_next = ({1'b0, ph_inc} == PERIOD_CNT) ? '0 : ph_inc;
		left_on  = (ph_next < left_duty_q);
		right_on = (ph_next < right_duty_q);
		// off phase: leg a follows leg b
		pins_next[1] = left_on ? cfg.reverse : pins_q[1];
		pins_next[0] = left_on ? !cfg.reverse : pins_q[1];
		pins_next[3] = right_on ? !cfg.reverse : pins_q[3];
		pins_next[2] = right_on ? cfg.reverse : pins_q[3];
		recip_prod = spbd_pkg::RECIP_W'(rem_q) * spbd_pkg::RECIP_W'(spbd_pkg::RECIP_M);
		quot_fix   = quot_q
			+ spbd_pkg::QUOT_W'(rem_q >= spbd_pkg::PROD_W'(spbd_pkg::DIFF_DEN));
	end

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= '0;
			left_duty_q  <= 7'd50;
			right_duty_q <= 7'd50;
			pins_q       <= 4'd0;
			out_valid_q  <= 1'b0;
			step_q       <= 3'd0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (!op.is_sample) begin
							phase_q <= ph_next;
							pins_q  <= pins_next;
							state_q <= ST_EMIT;
						end else if (op.scaled <= spbd_pkg::DEAD_BAND) begin
							left_duty_q  <= cfg.base_speed;
							right_duty_q <= cfg.base_speed;
							state_q      <= ST_EMIT;
						end else if (op.scaled >= spbd_pkg::DIFF_DEN) begin
							// 2000 mV or more stops the slow wheel
							left_duty_q  <= op.left_high ? '0 : cfg.base_speed;
							right_duty_q <= op.left_high ? cfg.base_speed : '0;
							state_q      <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q  <= 3'd2;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == 3'd0) begin
						left_duty_q  <= left_high_q ? quot_fix : cfg.base_speed;
						right_duty_q <= left_high_q ? cfg.base_speed : quot_fix;
						state_q      <= ST_EMIT;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_empty) begin
			left_high_q <= op.left_high;
			remain_q    <= spbd_pkg::REMAIN_W'(spbd_pkg::DIFF_DEN - op.scaled);
		end
		if (state_q == ST_MUL) begin
			rem_q <= spbd_pkg::PROD_W'(cfg.base_speed) * spbd_pkg::PROD_W'(remain_q);
		end
		// divide by the constant: reciprocal estimate, back-multiply, one compare
		if (state_q == ST_DIV && step_q == 3'd2) begin
			quot_q <= recip_prod[spbd_pkg::RECIP_SHIFT +: spbd_pkg::QUOT_W];
		end
		if (state_q == ST_DIV && step_q == 3'd1) begin
			rem_q <= rem_q - spbd_pkg::PROD_W'(quot_q) * spbd_pkg::PROD_W'(spbd_pkg::DIFF_DEN);
		end
		if (state_q == ST_EMIT && (!out_valid_q || out_ready)) begin
			out_res_q.left_pin_a  <= pins_q[0];
			out_res_q.left_pin_b  <= pins_q[1];
			out_res_q.right_pin_a <= pins_q[2];
			out_res_q.right_pin_b <= pins_q[3];
			out_res_q.left_level  <= left_duty_q;
			out_res_q.right_level <= right_duty_q;
		end
	end

endmodule

// ===== dv/spbd_dv_pkg.sv =====
`timescale 1ns / 100ps
// request kinds and register codes shared by the steering driver testbench files
package spbd_dv_pkg;

	typedef enum logic {
		REQ_TICK   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_kind_e;

	// index with no register behind it, writes are ignored
	localparam logic [1:0] CFG_UNUSED = 2'd3;

endpackage

// ===== dv/steering_pwm_bridge_driver_checker.sv =====
`timescale 1ns / 100ps
// checker that predicts bridge pins and wheel duties and compares them with the block
module steering_pwm_bridge_driver_checker #(
	parameter int PWM_PERIOD = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        s_tuser,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output int unsigned mismatch_count,
	output int unsigned open_count
);

	// 2000 mV and 10 mV, both scaled by 1023 counts
	localparam longint unsigned CUT_DEN  = 64'd2046000;
	localparam longint unsigned DEAD_LIM = 64'd10230;

	logic [6:0]  set_base = 7'd50;
	logic        set_rev  = 1'b0;
	logic [12:0] set_fs   = 13'd3300;

	logic [6:0]  phase  = '0;
	logic [6:0]  duty_l = 7'd50;
	logic [6:0]  duty_r = 7'd50;
	logic [3:0]  pins   = '0;

	spbd_pkg::res_t expected_drive[$];
	int unsigned    fails = 0;
	int unsigned    result_index = 0;

	function automatic logic [6:0] cut_duty(input longint unsigned scaled);
		longint unsigned remain;
		if (scaled >= CUT_DEN)
			return '0;
		remain = CUT_DEN - scaled;
		return 7'((64'(set_base) * remain) / CUT_DEN);
	endfunction

	task automatic take_pair(input logic [9:0] lft, input logic [9:0] rgt);
		logic [9:0]      mag;
		logic            left_up;
		longint unsigned scaled;
		left_up = (lft >= rgt);
		mag = left_up ? lft - rgt : rgt - lft;
		scaled = 64'(mag) * 64'(set_fs);
		if (scaled > DEAD_LIM && left_up) begin
			duty_l = cut_duty(scaled);
			duty_r = set_base;
		end else if (scaled > DEAD_LIM) begin
			duty_r = cut_duty(scaled);
			duty_l = set_base;
		end else begin
			duty_l = set_base;
			duty_r = set_base;
		end
	endtask

	task automatic take_tick();
		logic la, lb, ra, rb;
		{rb, ra, lb, la} = pins;
		phase = phase + 7'd1;
		if (32'(phase) == PWM_PERIOD)
			phase = '0;
		// on phase drives the bridge, off phase copies leg b onto leg a
		if (phase < duty_l) begin
			la = ~set_rev;
			lb = set_rev;
		end else begin
			la = lb;
		end
		if (phase < duty_r) begin
			ra = set_rev;
			rb = ~set_rev;
		end else begin
			ra = rb;
		end
		pins = {rb, ra, lb, la};
	endtask

	task automatic check_field(input string what, input logic [6:0] want,
		input logic [6:0] got);
		if (want != got) begin
			fails++;
			if (fails <= 10)
				$display("drive_check: result %0d %s expected %0d got %0d",
					result_index, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		spbd_pkg::res_t want;
		spbd_pkg::res_t got;
		if (!arst_n) begin
			set_base = 7'd50;
			set_rev = 1'b0;
			set_fs = 13'd3300;
			phase = '0;
			duty_l = 7'd50;
			duty_r = 7'd50;
			pins = '0;
			expected_drive.delete();
			fails = 0;
			result_index = 0;
			mismatch_count <= 0;
			open_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_drive.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("drive_check: result %0d arrived with nothing pending, data %h",
							result_index, m_tdata);
				end else begin
					want = expected_drive.pop_front();
					got = spbd_pkg::res_t'(m_tdata[17:0]);
					check_field("left_pin_a", 7'(want.left_pin_a), 7'(got.left_pin_a));
					check_field("left_pin_b", 7'(want.left_pin_b), 7'(got.left_pin_b));
					check_field("right_pin_a", 7'(want.right_pin_a), 7'(got.right_pin_a));
					check_field("right_pin_b", 7'(want.right_pin_b), 7'(got.right_pin_b));
					check_field("left_level", want.left_level, got.left_level);
					check_field("right_level", want.right_level, got.right_level);
					check_field("pad", 7'd0, 7'(m_tdata[23:18]));
				end
				result_index++;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					spbd_pkg::CFG_BASE_SPEED:    set_base = cfg_data[6:0];
					spbd_pkg::CFG_REVERSE:       set_rev = cfg_data[0];
					spbd_pkg::CFG_FULL_SCALE_MV: set_fs = cfg_data;
					default:                     ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == spbd_dv_pkg::REQ_SAMPLE)
					take_pair(s_tdata[9:0], s_tdata[19:10]);
				else
					take_tick();
				want.left_pin_a = pins[0];
				want.left_pin_b = pins[1];
				want.right_pin_a = pins[2];
				want.right_pin_b = pins[3];
				want.left_level = duty_l;
				want.right_level = duty_r;
				expected_drive.push_back(want);
			end

			open_count <= expected_drive.size();
			mismatch_count <= fails;
		end
	end

endmodule

// ===== dv/steering_pwm_bridge_driver_top_test.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus and verdict for the steering pwm bridge driver
module steering_pwm_bridge_driver_top_test;

	localparam int PERIOD_TICKS = 100;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_GRACE = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tuser = 1'b0;
	logic [23:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;
	logic        cfg_ready;

	int unsigned mismatch_count;
	int unsigned open_count;
	int          burst_left = 0;
	bit          hold_request = 1'b0;

	steering_pwm_bridge_driver_top #(
		.PWM_PERIOD(PERIOD_TICKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	steering_pwm_bridge_driver_checker #(
		.PWM_PERIOD(PERIOD_TICKS)
	) drive_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.open_count(open_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sender works in bursts, a burst ends in an idle gap that may be empty
	task automatic send_item(input spbd_dv_pkg::req_kind_e kind, input logic [9:0] lft,
		input logic [9:0] rgt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'd0, rgt, lft};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random();
		logic [9:0] lft;
		logic [9:0] rgt;
		int         near;
		int         pick;
		lft = 10'($urandom);
		rgt = 10'($urandom);
		if ($urandom_range(0, 9) >= 3) begin
			send_item(spbd_dv_pkg::REQ_TICK, lft, rgt);
		end else begin
			pick = $urandom_range(0, 3);
			if (pick == 0) begin
				// small differences around the dead band
				near = int'(lft) + int'($urandom_range(0, 16)) - 8;
				if (near < 0)
					near = 0;
				if (near > 1023)
					near = 1023;
				rgt = 10'(near);
			end else if (pick == 1) begin
				lft = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
				rgt = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
			end
			send_item(spbd_dv_pkg::REQ_SAMPLE, lft, rgt);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [12:0] base_raw, input logic [12:0] rev_raw,
		input logic [12:0] fs_raw);
		write_reg(spbd_pkg::CFG_BASE_SPEED, base_raw);
		write_reg(spbd_pkg::CFG_REVERSE, rev_raw);
		write_reg(spbd_pkg::CFG_FULL_SCALE_MV, fs_raw);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, wait for every pending result, then let the back end go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (SETTLE_GRACE) @(posedge clk);
	endtask

	task automatic random_phase(input logic [12:0] base_raw, input logic [12:0] rev_raw,
		input logic [12:0] fs_raw, input int count);
		configure(base_raw, rev_raw, fs_raw);
		repeat (count) send_random();
		settle();
	endtask

	initial begin : sink
		int busy_pct;
		int span;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			busy_pct = $urandom_range(0, 3) * 25;
			span = $urandom_range(4, 64);
			repeat (span) begin
				m_tready <= ($urandom_range(1, 100) > busy_pct);
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: base 50, forward, 3300 mV full scale
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h3ff, 10'h3ff);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'h3ff, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h155, 10'h2aa);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'h000, 10'h3ff);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h2aa, 10'h155);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd512, 10'd512);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd103, 10'd100);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd100, 10'd104);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd700, 10'd300);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h3ff);
		settle();

		// a full 2000 mV difference lands exactly on the cut-off
		configure(13'd100, 13'd1, 13'd2000);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'h3ff, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd0, 10'd1022);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd0, 10'd1000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		settle();

		// difference exactly at the dead band edge, base above the period
		configure(13'h1fff, 13'd0, 13'd3410);
		write_reg(spbd_dv_pkg::CFG_UNUSED, 13'h155a);
		cfg_valid <= 1'b0;
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd3, 10'd0);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'd0, 10'd4);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		settle();

		// zero full scale means no steering at all
		configure(13'd64, 13'd1, 13'd0);
		send_item(spbd_dv_pkg::REQ_SAMPLE, 10'h3ff, 10'h000);
		send_item(spbd_dv_pkg::REQ_TICK, 10'h000, 10'h000);
		settle();

		hold_request = 1'b1;
		random_phase(13'd50, 13'd0, 13'd3300, 200);
		random_phase(13'd100, 13'd1, 13'd5000, 150);
		random_phase(13'd0, 13'd0, 13'd1000, 100);
		random_phase(13'h1fff, 13'h1fff, 13'h1fff, 150);
		random_phase(13'($urandom_range(0, 100)), 13'($urandom_range(0, 1)),
			13'($urandom_range(1000, 5000)), 100);
		random_phase(13'd100, 13'h1ffe, 13'd0, 100);
		random_phase(13'($urandom), 13'($urandom), 13'($urandom), 100);

		if (mismatch_count == 0 && open_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
